// File: design/sfb_pkg.sv
// ----------------------------------------------------------------------------
// sfb_pkg: shared types and constants of the stuffed parameter frame builder
// Item layouts, command and status codes, register indexes, kind tables.
// ----------------------------------------------------------------------------
package sfb_pkg;

	localparam int EMIT_MAX        = 13;	// longest byte list one command emits
	localparam int EMIT_CW         = 4;	// width of a count over that list
	localparam int KIND_COUNT      = 10;
	localparam int TRAILER_RESERVE = 6;	// two doubled length bytes plus trailer
	localparam int HEAD_BYTES      = 4;

	typedef enum logic [1:0] {
		CMD_BEGIN = 2'd0,
		CMD_ADD   = 2'd1,
		CMD_END   = 2'd2,
		CMD_READ  = 2'd3
	} cmd_code_t;

	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_DROPPED = 2'd1,
		STAT_EMPTY   = 2'd2
	} stat_code_t;

	typedef enum logic [1:0] {
		REG_CONTROL_CHAR = 2'd0,
		REG_FRAME_START  = 2'd1,
		REG_FRAME_END    = 2'd2,
		REG_PARAM_START  = 2'd3
	} reg_index_t;

	typedef struct packed {
		logic [1:0]  command;
		logic [3:0]  param_kind;
		logic [15:0] param_index;
		logic [63:0] param_value;
	} cmd_item_t;

	typedef struct packed {
		logic [7:0]  read_byte;
		logic [15:0] frame_length;
		logic [1:0]  status;
		logic        last_byte;
	} rsp_item_t;

	// byte list handed to the emitter
	typedef struct packed {
		logic [EMIT_MAX-1:0][7:0] bytes;
		logic [EMIT_MAX-1:0]      stuff;
		logic [EMIT_CW-1:0]       count;
	} emit_load_t;

	// one store write per cycle from the emitter
	typedef struct packed {
		logic       valid;
		logic [7:0] data;
		logic       last;
	} emit_out_t;

	function automatic logic [7:0] kind_code(input logic [3:0] kind);
		logic [7:0] code;
		case (kind)
			4'd0:    code = 8'h11;
			4'd1:    code = 8'h12;
			4'd2:    code = 8'h21;
			4'd3:    code = 8'h22;
			4'd4:    code = 8'h41;
			4'd5:    code = 8'h42;
			4'd6:    code = 8'h43;
			4'd7:    code = 8'h81;
			4'd8:    code = 8'h82;
			4'd9:    code = 8'h83;
			default: code = 8'h00;
		endcase
		return code;
	endfunction

	function automatic logic [3:0] kind_nbytes(input logic [3:0] kind);
		logic [3:0] nb;
		case (kind)
			4'd0, 4'd1:       nb = 4'd1;
			4'd2, 4'd3:       nb = 4'd2;
			4'd4, 4'd5, 4'd6: nb = 4'd4;
			4'd7, 4'd8, 4'd9: nb = 4'd8;
			default:          nb = 4'd0;
		endcase
		return nb;
	endfunction

endpackage

// File: design/sfb_chan_if.sv
// ----------------------------------------------------------------------------
// sfb_chan_if: valid/ready channel
// Carries one item per handshake; the payload type is set per instance.
// ----------------------------------------------------------------------------
interface sfb_chan_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

// File: design/stuffed_parameter_frame_builder_unit.sv
// ----------------------------------------------------------------------------
// stuffed_parameter_frame_builder_unit: byte-stuffed parameter frame builder
// Assembles one frame in a byte store and hands it out a byte per read.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries one command item (begin, add parameter, end, read); rsp returns
//   exactly one result item per command. An item is taken when valid and
//   ready are both high. cfg_write_en/cfg_index/cfg_data set the control char
//   and the start, end and parameter-start bytes; write them only while idle.
// Sequencing: an accepted command is dispatched, then begin, add and end
//   pass their byte lists to the emitter, read fetches one byte from the
//   store or the length registers, and dropped or ignored commands go
//   straight to the result. The emitter writes one byte a cycle through the
//   single store write port. One command is worked on at a time; the next
//   one is taken the cycle after the result is loaded.
// Length slot: the end command does not move the body. Doubled length bytes
//   are held in registers and the read address is offset past them, so end
//   costs only its four trailer writes.
// Reset: configuration returns to its defaults, no frame is open, fill and
//   read positions are zero. Store contents are not cleared; every byte that
//   a read can reach is written by the frame that holds it.
// Stall: the result waits in an output register; one more command may be
//   taken meanwhile and its result is held until the register frees.
// ----------------------------------------------------------------------------
module stuffed_parameter_frame_builder_unit #(
	parameter int FRAME_BYTES = 512
) (
	input  logic       clk,
	input  logic       arst_n,
	sfb_chan_if.sink   cmd,
	sfb_chan_if.source rsp,
	input  logic       cfg_write_en,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data
);
	localparam int PW = $clog2(FRAME_BYTES + 1);	// positions up to FRAME_BYTES
	localparam int AW = $clog2(FRAME_BYTES);	// store address
	localparam int SW = PW + 1;			// room check sum

	typedef enum logic [2:0] {
		S_IDLE,
		S_DISPATCH,
		S_EMIT,
		S_READ,
		S_DONE
	} state_t;

	state_t                 state_q;
	sfb_pkg::cmd_item_t     item_q;
	sfb_pkg::rsp_item_t     rsp_item_q;
	logic                   rsp_valid_q;

	logic [7:0]             ctrl_q;
	logic [7:0]             fstart_q;
	logic [7:0]             fend_q;
	logic [7:0]             pstart_q;

	logic [PW-1:0]          wp_q;
	logic [PW-1:0]          rp_q;
	logic [7:0]             xor_q;
	logic                   closed_q;
	logic [15:0]            len_q;		// length written into the slot
	logic                   dh_q;		// high length byte doubled
	logic                   dl_q;		// low length byte doubled
	logic [7:0]             rbyte_q;
	logic                   last_q;
	logic [1:0]             stat_q;

	logic [1:0]             extra;
	logic                   frame_open;
	logic                   kind_ok;
	logic [7:0]             code;
	logic [3:0]             nb;
	logic [63:0]            aligned;
	logic [sfb_pkg::EMIT_MAX-1:0][7:0] add_bytes;
	logic [sfb_pkg::EMIT_MAX-1:0]      add_stuff;
	logic [sfb_pkg::EMIT_MAX-1:0]      add_match;
	logic [4:0]             need;
	logic                   overflow;
	logic [15:0]            wp16;
	logic                   end_dh;
	logic                   end_dl;
	logic [7:0]             end_xor;
	logic                   can_read;
	logic                   in_len;
	logic [1:0]             len_k;
	logic [7:0]             len_byte;
	logic                   out_free;

	sfb_pkg::emit_load_t    load_data;
	logic                   load;
	sfb_pkg::emit_out_t     emit;

	logic                   ram_we;
	logic [AW-1:0]          ram_waddr;
	logic [AW-1:0]          ram_raddr;
	logic [7:0]             ram_rdata;

	assign extra      = {1'b0, dh_q} + {1'b0, dl_q};
	assign frame_open = !closed_q && (wp_q >= PW'(sfb_pkg::HEAD_BYTES));
	assign out_free   = !rsp_valid_q || rsp.ready;

	// Parameter record: control char, then stuffed start, code, index, value.
	always_comb begin
		kind_ok = item_q.param_kind < 4'(sfb_pkg::KIND_COUNT);
		code    = sfb_pkg::kind_code(item_q.param_kind);
		nb      = sfb_pkg::kind_nbytes(item_q.param_kind);
		// left-align the value so byte i is always the same slice
		case (nb)
			4'd1:    aligned = item_q.param_value << 56;
			4'd2:    aligned = item_q.param_value << 48;
			4'd4:    aligned = item_q.param_value << 32;
			default: aligned = item_q.param_value;
		endcase
		add_bytes[0] = ctrl_q;
		add_bytes[1] = pstart_q;
		add_bytes[2] = code;
		add_bytes[3] = item_q.param_index[15:8];
		add_bytes[4] = item_q.param_index[7:0];
		for (int i = 0; i < 8; i++) begin
			add_bytes[5 + i] = aligned[63 - 8 * i -: 8];
		end
		for (int j = 0; j < sfb_pkg::EMIT_MAX; j++) begin
			add_stuff[j] = (j >= 1) && (5'(j) < 5'(5) + 5'(nb));
			add_match[j] = add_stuff[j] && (add_bytes[j] == ctrl_q);
		end
		need     = 5'(5) + 5'(nb) + 5'($countones(add_match));
		overflow = (SW'(wp_q) + SW'(need) + SW'(sfb_pkg::TRAILER_RESERVE)) > SW'(FRAME_BYTES);
	end

	// End: length value and trailer checksum; a doubled byte cancels in the XOR.
	always_comb begin
		wp16    = 16'(wp_q);
		end_dh  = wp16[15:8] == ctrl_q;
		end_dl  = wp16[7:0] == ctrl_q;
		end_xor = xor_q ^ (end_dh ? 8'h00 : wp16[15:8]) ^ (end_dl ? 8'h00 : wp16[7:0]);
	end

	// Pick the emitter's byte list for the dispatched command.
	always_comb begin
		load_data = '0;
		load      = 1'b0;
		case (item_q.command)
			sfb_pkg::CMD_BEGIN: begin
				load_data.bytes[0] = ctrl_q;
				load_data.bytes[1] = fstart_q;
				load_data.count    = sfb_pkg::EMIT_CW'(sfb_pkg::HEAD_BYTES);
				load               = state_q == S_DISPATCH;
			end
			sfb_pkg::CMD_ADD: begin
				load_data.bytes = add_bytes;
				load_data.stuff = add_stuff;
				load_data.count = sfb_pkg::EMIT_CW'(5'(5) + 5'(nb));
				load            = (state_q == S_DISPATCH) && frame_open && kind_ok && !overflow;
			end
			sfb_pkg::CMD_END: begin
				load_data.bytes[0] = ctrl_q;
				load_data.bytes[1] = fend_q;
				load_data.bytes[2] = end_xor;
				load_data.count    = sfb_pkg::EMIT_CW'(4);
				load               = (state_q == S_DISPATCH) && frame_open;
			end
			default: begin
				load = 1'b0;
			end
		endcase
	end

	sfb_emitter u_emitter (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.load_data (load_data),
		.ctrl_char (ctrl_q),
		.emit      (emit)
	);

	// Store writes land at the unshifted position; reads skip the length area.
	assign ram_we    = emit.valid;
	assign ram_waddr = AW'(wp_q - PW'(extra));
	assign ram_raddr = (rp_q < PW'(2)) ? AW'(rp_q) : AW'(rp_q - PW'(extra));

	sfb_ram #(
		.WIDTH (8),
		.DEPTH (FRAME_BYTES)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (emit.data),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Read side: length bytes come from registers, the rest from the store.
	always_comb begin
		can_read = closed_q && (rp_q < wp_q);
		in_len   = (rp_q >= PW'(2)) && (rp_q < PW'(sfb_pkg::HEAD_BYTES) + PW'(extra));
		len_k    = 2'(rp_q - PW'(2));
		case (len_k)
			2'd0:    len_byte = len_q[15:8];
			2'd1:    len_byte = dh_q ? len_q[15:8] : len_q[7:0];
			default: len_byte = len_q[7:0];
		endcase
	end

	assign cmd.ready   = state_q == S_IDLE;
	assign rsp.valid   = rsp_valid_q;
	assign rsp.payload = rsp_item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			item_q      <= '0;
			rsp_item_q  <= '0;
			rsp_valid_q <= 1'b0;
			ctrl_q      <= 8'd213;
			fstart_q    <= 8'd1;
			fend_q      <= 8'd2;
			pstart_q    <= 8'd3;
			wp_q        <= '0;
			rp_q        <= '0;
			xor_q       <= '0;
			closed_q    <= 1'b0;
			len_q       <= '0;
			dh_q        <= 1'b0;
			dl_q        <= 1'b0;
			rbyte_q     <= '0;
			last_q      <= 1'b0;
			stat_q      <= sfb_pkg::STAT_OK;
		end else begin
			if (cfg_write_en) begin
				case (cfg_index)
					sfb_pkg::REG_CONTROL_CHAR: ctrl_q   <= cfg_data;
					sfb_pkg::REG_FRAME_START:  fstart_q <= cfg_data;
					sfb_pkg::REG_FRAME_END:    fend_q   <= cfg_data;
					sfb_pkg::REG_PARAM_START:  pstart_q <= cfg_data;
					default:                   ctrl_q   <= ctrl_q;
				endcase
			end

			// drop the result once taken; in S_DONE a new result replaces it
			if (rsp_valid_q && rsp.ready && (state_q != S_DONE)) begin
				rsp_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (cmd.valid) begin
						item_q  <= cmd.payload;
						rbyte_q <= '0;
						last_q  <= 1'b0;
						stat_q  <= sfb_pkg::STAT_OK;
						state_q <= S_DISPATCH;
					end
				end
				S_DISPATCH: begin
					case (item_q.command)
						sfb_pkg::CMD_BEGIN: begin
							wp_q     <= '0;
							rp_q     <= '0;
							xor_q    <= '0;
							closed_q <= 1'b0;
							dh_q     <= 1'b0;
							dl_q     <= 1'b0;
							state_q  <= S_EMIT;
						end
						sfb_pkg::CMD_ADD: begin
							if (!frame_open || !kind_ok) begin
								state_q <= S_DONE;
							end else if (overflow) begin
								stat_q  <= sfb_pkg::STAT_DROPPED;
								state_q <= S_DONE;
							end else begin
								state_q <= S_EMIT;
							end
						end
						sfb_pkg::CMD_END: begin
							if (frame_open) begin
								// count the doubled length bytes; trailer goes after them
								len_q    <= wp16;
								dh_q     <= end_dh;
								dl_q     <= end_dl;
								wp_q     <= wp_q + PW'({1'b0, end_dh} + {1'b0, end_dl});
								closed_q <= 1'b1;
								rp_q     <= '0;
								state_q  <= S_EMIT;
							end else begin
								state_q <= S_DONE;
							end
						end
						default: begin
							if (can_read) begin
								state_q <= S_READ;
							end else begin
								stat_q  <= sfb_pkg::STAT_EMPTY;
								state_q <= S_DONE;
							end
						end
					endcase
				end
				S_EMIT: begin
					// advance the fill position with every store write
					wp_q  <= wp_q + PW'(1);
					xor_q <= xor_q ^ emit.data;
					if (emit.last) begin
						state_q <= S_DONE;
					end
				end
				S_READ: begin
					rbyte_q <= in_len ? len_byte : ram_rdata;
					last_q  <= (rp_q + PW'(1)) == wp_q;
					rp_q    <= rp_q + PW'(1);
					state_q <= S_DONE;
				end
				S_DONE: begin
					// hold until the output register is free
					if (out_free) begin
						rsp_item_q.read_byte    <= rbyte_q;
						rsp_item_q.frame_length <= 16'(wp_q);
						rsp_item_q.status       <= stat_q;
						rsp_item_q.last_byte    <= last_q;
						rsp_valid_q             <= 1'b1;
						state_q                 <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Fill never passes the store size; the room check keeps end in bounds.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wp_q <= PW'(FRAME_BYTES))
		else $error("fill position beyond store size");

	// A closed frame never reads past its last byte.
	a_read_bound: assert property (@(posedge clk) disable iff (!arst_n)
		closed_q |-> rp_q <= wp_q)
		else $error("read position beyond frame length");

	// The emitter writes the store only while the sequencer waits on it.
	a_emit_state: assert property (@(posedge clk) disable iff (!arst_n)
		emit.valid |-> state_q == S_EMIT)
		else $error("store write outside emit phase");

	// An empty read returns no data and no last mark.
	a_empty_read: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.payload.status == sfb_pkg::STAT_EMPTY)
		|-> (rsp.payload.read_byte == 8'h00 && !rsp.payload.last_byte))
		else $error("empty read carries data");
endmodule

// File: design/sfb_ram.sv
// ----------------------------------------------------------------------------
// sfb_ram: generic memory
// One write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module sfb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: design/sfb_emitter.sv
// ----------------------------------------------------------------------------
// sfb_emitter: byte stuffing sequencer
// Steps through a loaded byte list, one store write a cycle, and writes a
// byte twice when it is marked for stuffing and equals the control char.
// ----------------------------------------------------------------------------
module sfb_emitter (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  sfb_pkg::emit_load_t load_data,
	input  logic [7:0]          ctrl_char,
	output sfb_pkg::emit_out_t  emit
);
	logic [sfb_pkg::EMIT_MAX-1:0][7:0] bytes_q;
	logic [sfb_pkg::EMIT_MAX-1:0]      stuff_q;
	logic [sfb_pkg::EMIT_CW-1:0]       count_q;
	logic [sfb_pkg::EMIT_CW-1:0]       idx_q;
	logic                              dup_q;
	logic                              busy_q;
	logic [7:0]                        cur;
	logic                              dbl;
	logic                              hold;

	// shared compare: one byte against the control char each cycle
	always_comb begin
		cur       = bytes_q[idx_q];
		dbl       = stuff_q[idx_q] && (cur == ctrl_char);
		hold      = dbl && !dup_q;
		emit.valid = busy_q;
		emit.data  = cur;
		emit.last  = busy_q && !hold && (idx_q == (count_q - sfb_pkg::EMIT_CW'(1)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_q <= '0;
			stuff_q <= '0;
			count_q <= '0;
			idx_q   <= '0;
			dup_q   <= 1'b0;
			busy_q  <= 1'b0;
		end else if (load) begin
			bytes_q <= load_data.bytes;
			stuff_q <= load_data.stuff;
			count_q <= load_data.count;
			idx_q   <= '0;
			dup_q   <= 1'b0;
			busy_q  <= 1'b1;
		end else if (busy_q) begin
			if (hold) begin
				dup_q <= 1'b1;
			end else begin
				dup_q <= 1'b0;
				idx_q <= idx_q + sfb_pkg::EMIT_CW'(1);
				if (emit.last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end
endmodule

// File: dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the stuffed parameter frame builder
// Drives begin, add, end and read commands through the cmd channel, predicts
// every result from a local frame image, and checks each result field by field
// under several register settings and sender/receiver idling mixes.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int FRAME_BYTES    = 512;
	localparam int RESET_CYCLES   = 11;
	localparam int PAUSE_CYCLES   = 40;	// longest add latency plus margin
	localparam int WATCHDOG_LIMIT = 2000;	// cycles with no handshake at all
	localparam int SETTLE_LIMIT   = 4000;
	localparam int ITEM_TARGET    = 900;	// whole run, directed tests included
	localparam int CHUNK_MIN      = 20;	// least items under one register setting
	localparam int REPORT_LINES   = 30;

	// parameter kinds, in the order of the kind field
	typedef enum logic [3:0] {
		K_I8, K_U8, K_I16, K_U16, K_I32, K_U32, K_F32, K_I64, K_U64, K_F64
	} param_kind_t;

	// type code and value width of each kind, kind 0 in the lowest slot
	localparam logic [sfb_pkg::KIND_COUNT-1:0][7:0] TYPE_CODE = {
		8'h83, 8'h82, 8'h81, 8'h43, 8'h42, 8'h41, 8'h22, 8'h21, 8'h12, 8'h11
	};
	localparam logic [sfb_pkg::KIND_COUNT-1:0][3:0] KIND_WIDTH = {
		4'd8, 4'd8, 4'd8, 4'd4, 4'd4, 4'd4, 4'd2, 4'd2, 4'd1, 4'd1
	};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_write_en;
	logic [1:0] cfg_index;
	logic [7:0] cfg_data;

	sfb_chan_if #(.payload_t(sfb_pkg::cmd_item_t)) cmd_ch ();
	sfb_chan_if #(.payload_t(sfb_pkg::rsp_item_t)) rsp_ch ();

	stuffed_parameter_frame_builder_unit #(
		.FRAME_BYTES(FRAME_BYTES)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd_ch),
		.rsp         (rsp_ch),
		.cfg_write_en(cfg_write_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always #2 clk = ~clk;

	// ------------------------------------------------------------------------
	// Frame image: what the block should hold after every accepted command.
	// Registers start at their reset defaults.
	// ------------------------------------------------------------------------
	logic [7:0]  cfg_ctrl   = 8'd213;
	logic [7:0]  cfg_fstart = 8'd1;
	logic [7:0]  cfg_fend   = 8'd2;
	logic [7:0]  cfg_pstart = 8'd3;
	logic [7:0]  frame_mem [FRAME_BYTES];
	int unsigned frame_fill = 0;
	int unsigned read_pos = 0;
	logic        frame_done = 1'b0;

	sfb_pkg::rsp_item_t replies_due [$];	// one expected result per accepted command

	int send_idle_pct = 16;
	int recv_idle_pct = 77;
	int unsigned items_sent = 0;
	int unsigned results_checked = 0;
	int unsigned mismatches = 0;
	int unsigned frames_closed = 0;
	int unsigned drops_seen = 0;
	int unsigned settings_used = 0;
	int unsigned quiet_cycles = 0;

	// append one byte; past the store only the count moves
	function automatic void put_raw(input logic [7:0] b);
		if (frame_fill < FRAME_BYTES)
			frame_mem[frame_fill] = b;
		frame_fill++;
	endfunction

	// data bytes equal to the control char go in twice
	function automatic void put_stuffed(input logic [7:0] b);
		put_raw(b);
		if (b == cfg_ctrl)
			put_raw(b);
	endfunction

	// advance the frame image by one command and return the result it gives
	function automatic sfb_pkg::rsp_item_t apply_command(input sfb_pkg::cmd_item_t it);
		sfb_pkg::rsp_item_t r;
		logic [7:0]  rec [$];
		logic [7:0]  body [$];
		logic [7:0]  hi, lo, sum;
		int unsigned nb, need;
		logic        is_open;
		r = '0;
		is_open = !frame_done && frame_fill >= sfb_pkg::HEAD_BYTES;
		case (it.command)
			sfb_pkg::CMD_BEGIN: begin
				frame_mem[0] = cfg_ctrl;
				frame_mem[1] = cfg_fstart;
				frame_mem[2] = 8'h00;
				frame_mem[3] = 8'h00;
				frame_fill = sfb_pkg::HEAD_BYTES;
				read_pos = 0;
				frame_done = 1'b0;
			end
			sfb_pkg::CMD_ADD: begin
				if (is_open && it.param_kind < sfb_pkg::KIND_COUNT) begin
					nb = KIND_WIDTH[it.param_kind];
					rec = {cfg_pstart, TYPE_CODE[it.param_kind],
						it.param_index[15:8], it.param_index[7:0]};
					// value goes out big-endian from its low nb bytes
					for (int i = nb - 1; i >= 0; i--)
						rec.push_back(it.param_value[i*8 +: 8]);
					need = 1;
					foreach (rec[i])
						need += (rec[i] == cfg_ctrl) ? 2 : 1;
					// keep room for two doubled length bytes and the trailer
					if (frame_fill + need + sfb_pkg::TRAILER_RESERVE > FRAME_BYTES) begin
						r.status = sfb_pkg::STAT_DROPPED;
						drops_seen++;
					end else begin
						put_raw(cfg_ctrl);
						foreach (rec[i])
							put_stuffed(rec[i]);
					end
				end
			end
			sfb_pkg::CMD_END: begin
				if (is_open) begin
					hi = frame_fill[15:8];
					lo = frame_fill[7:0];
					for (int i = sfb_pkg::HEAD_BYTES; i < frame_fill; i++)
						body.push_back(frame_mem[i]);
					// rewrite from the length slot, body follows the length bytes
					frame_fill = 2;
					put_stuffed(hi);
					put_stuffed(lo);
					foreach (body[i])
						put_raw(body[i]);
					sum = 8'h00;
					for (int i = 0; i < frame_fill; i++)
						sum ^= frame_mem[i];
					put_raw(cfg_ctrl);
					put_raw(cfg_fend);
					put_raw(sum);
					put_raw(8'h00);
					frame_done = 1'b1;
					read_pos = 0;
					frames_closed++;
				end
			end
			sfb_pkg::CMD_READ: begin
				if (frame_done && read_pos < frame_fill && read_pos < FRAME_BYTES) begin
					r.read_byte = frame_mem[read_pos];
					r.last_byte = (read_pos + 1 == frame_fill);
					read_pos++;
				end else begin
					r.status = sfb_pkg::STAT_EMPTY;
				end
			end
			default: begin
			end
		endcase
		r.frame_length = frame_fill[15:0];
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------
	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		if (mismatches < REPORT_LINES)
			$display("MISMATCH result %0d %s: got %0h, expected %0h",
				results_checked, what, got, want);
		mismatches++;
	endtask

	// present one item, hold it until taken, then predict its result
	task automatic send_item(input sfb_pkg::cmd_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.payload <= it;
		do @(posedge clk); while (!cmd_ch.ready);
		replies_due.push_back(apply_command(it));
		items_sent++;
	endtask

	// drop valid and wait for every outstanding result, up to the settle limit, then wait the extra cycles given
	task automatic settle(input int unsigned extra);
		int unsigned waited;
		cmd_ch.valid <= 1'b0;
		waited = 0;
		do begin
			@(posedge clk);
			waited++;
		end while (replies_due.size() != 0 && waited < SETTLE_LIMIT);
		repeat (extra) @(posedge clk);
	endtask

	task automatic write_reg(input sfb_pkg::reg_index_t idx, input logic [7:0] val);
		cfg_write_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	// call only after settle: the block must be idle
	task automatic write_config(input logic [7:0] cc, fs, fe, ps);
		write_reg(sfb_pkg::REG_CONTROL_CHAR, cc);
		write_reg(sfb_pkg::REG_FRAME_START, fs);
		write_reg(sfb_pkg::REG_FRAME_END, fe);
		write_reg(sfb_pkg::REG_PARAM_START, ps);
		cfg_write_en <= 1'b0;
		cfg_ctrl = cc;
		cfg_fstart = fs;
		cfg_fend = fe;
		cfg_pstart = ps;
		settings_used++;
	endtask

	// command with random filler in the fields it does not use
	function automatic sfb_pkg::cmd_item_t any_fields(input sfb_pkg::cmd_code_t c);
		sfb_pkg::cmd_item_t it;
		it.command = c;
		it.param_kind = 4'($urandom_range(15));
		it.param_index = 16'($urandom);
		it.param_value = {$urandom, $urandom};
		return it;
	endfunction

	function automatic sfb_pkg::cmd_item_t make_param(input logic [3:0] kind,
			input logic [15:0] idx, input logic [63:0] val);
		sfb_pkg::cmd_item_t it;
		it.command = sfb_pkg::CMD_ADD;
		it.param_kind = kind;
		it.param_index = idx;
		it.param_value = val;
		return it;
	endfunction

	// bias data toward the control char so stuffing fires often
	function automatic logic [7:0] data_byte();
		return ($urandom_range(3) == 0) ? cfg_ctrl : 8'($urandom);
	endfunction

	function automatic sfb_pkg::cmd_item_t random_param();
		logic [63:0] val;
		logic [3:0]  kind;
		for (int i = 0; i < 8; i++)
			val[i*8 +: 8] = data_byte();
		kind = ($urandom_range(19) == 0) ? 4'($urandom_range(15, sfb_pkg::KIND_COUNT))
			: 4'($urandom_range(sfb_pkg::KIND_COUNT - 1));
		return make_param(kind, {data_byte(), data_byte()}, val);
	endfunction

	task automatic read_frame(input int unsigned count);
		repeat (count) send_item(any_fields(sfb_pkg::CMD_READ));
	endtask

	// well-formed frame with random content; some are left unfinished or
	// only partly read, most are read out one or two bytes past the end
	task automatic run_frame();
		int unsigned nparams;
		nparams = ($urandom_range(9) == 0) ? $urandom_range(24) : $urandom_range(6);
		send_item(any_fields(sfb_pkg::CMD_BEGIN));
		repeat (nparams) send_item(random_param());
		if ($urandom_range(9) == 0)
			return;
		send_item(any_fields(sfb_pkg::CMD_END));
		if ($urandom_range(9) == 0)
			read_frame($urandom_range(frame_fill));
		else
			read_frame(frame_fill + $urandom_range(2, 1));
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// no frame open yet: read reports empty, add and end do nothing
	task automatic test_no_frame();
		send_item(any_fields(sfb_pkg::CMD_READ));
		send_item(make_param(K_U32, 16'h1234, 64'h0123_4567_89AB_CDEF));
		send_item(any_fields(sfb_pkg::CMD_END));
	endtask

	// every kind, alternating lowest and highest index and value, unknown kinds,
	// commands after the frame is closed, and a read before end
	task automatic test_every_kind();
		send_item(any_fields(sfb_pkg::CMD_BEGIN));
		send_item(any_fields(sfb_pkg::CMD_READ));
		for (int k = 0; k < sfb_pkg::KIND_COUNT; k++)
			send_item(make_param(4'(k), k[0] ? 16'hFFFF : 16'h0000,
				k[0] ? {64{1'b1}} : 64'd0));
		// first and highest kinds past the table write nothing
		send_item(make_param(4'(sfb_pkg::KIND_COUNT), 16'hFFFF, {64{1'b1}}));
		send_item(make_param(4'hF, 16'h0000, 64'd0));
		send_item(any_fields(sfb_pkg::CMD_END));
		send_item(make_param(K_I8, 16'h0001, 64'h55));
		send_item(any_fields(sfb_pkg::CMD_END));
		read_frame(4);
	endtask

	// fill reaches the control char, so the low length byte is doubled and
	// the body shifts right by one
	task automatic test_length_escape();
		settle(PAUSE_CYCLES);
		write_config(8'h10, 8'h01, 8'h02, 8'h03);
		send_item(any_fields(sfb_pkg::CMD_BEGIN));
		send_item(make_param(K_I8, 16'h0000, 64'd0));
		send_item(make_param(K_I8, 16'h0000, 64'd0));
		send_item(any_fields(sfb_pkg::CMD_END));
		read_frame(frame_fill + 1);
	endtask

	// pack the store with fully stuffed records until one is dropped, send two
	// more records, then close and read the near-full frame
	task automatic test_overflow();
		int unsigned drops_at_start;
		int unsigned tries;
		drops_at_start = drops_seen;
		tries = 0;
		send_item(any_fields(sfb_pkg::CMD_BEGIN));
		while (drops_seen == drops_at_start && tries < 40) begin
			send_item(make_param(K_F64, {2{cfg_ctrl}}, {8{cfg_ctrl}}));
			tries++;
		end
		send_item(make_param(K_U64, {2{cfg_ctrl}}, {8{cfg_ctrl}}));
		send_item(make_param(K_U8, 16'h0000, 64'd0));
		send_item(any_fields(sfb_pkg::CMD_END));
		read_frame(frame_fill + 1);
	endtask

	// six register settings, two per idling mix; the remaining item budget
	// is spread over the settings
	task automatic test_random_frames();
		logic [7:0]  cc, fs, fe, ps;
		int unsigned chunk_end;
		for (int s = 0; s < 6; s++) begin
			if (s == 2) begin
				send_idle_pct = 77;
				recv_idle_pct = 16;
			end else if (s == 4) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			case (s)
				0: {cc, fs, fe, ps} = {8'd213, 8'd1, 8'd2, 8'd3};
				1: {cc, fs, fe, ps} = {8'h00, 8'hFF, 8'h00, 8'hFF};
				2: {cc, fs, fe, ps} = {8'hFF, 8'h00, 8'hFF, 8'h00};
				// control char equals the uint32 type code and every marker
				3: {cc, fs, fe, ps} = {8'h42, 8'h42, 8'h42, 8'h42};
				default: {cc, fs, fe, ps} = $urandom;
			endcase
			// hold off until the block is idle before touching registers
			settle(PAUSE_CYCLES);
			write_config(cc, fs, fe, ps);
			chunk_end = items_sent + CHUNK_MIN;
			if (ITEM_TARGET > chunk_end)
				chunk_end += (ITEM_TARGET - chunk_end) / (6 - s);
			while (items_sent < chunk_end) begin
				if ($urandom_range(99) < 15)
					repeat ($urandom_range(3, 1))
						send_item(any_fields(sfb_pkg::cmd_code_t'($urandom_range(3))));
				else
					run_frame();
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// Receiver: random stalls per the current mix
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// compare each accepted result with the oldest expectation
	always @(posedge clk) begin : check_results
		sfb_pkg::rsp_item_t got, want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got = rsp_ch.payload;
			if (replies_due.size() == 0) begin
				report_mismatch("arrived with nothing expected", got, 0);
			end else begin
				want = replies_due.pop_front();
				if (got.read_byte !== want.read_byte)
					report_mismatch("read_byte", got.read_byte, want.read_byte);
				if (got.frame_length !== want.frame_length)
					report_mismatch("frame_length", got.frame_length, want.frame_length);
				if (got.status !== want.status)
					report_mismatch("status", got.status, want.status);
				if (got.last_byte !== want.last_byte)
					report_mismatch("last_byte", got.last_byte, want.last_byte);
			end
			results_checked++;
		end
	end

	// end the run if neither channel moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= WATCHDOG_LIMIT) begin
					$display("Timeout: no handshake for %0d cycles", quiet_cycles);
					$display("Regression FAIL");
					$finish;
				end
			end
		end
	end

	initial begin
		cmd_ch.valid <= 1'b0;
		cmd_ch.payload <= '0;
		cfg_write_en <= 1'b0;
		cfg_index <= sfb_pkg::REG_CONTROL_CHAR;
		cfg_data <= 8'h00;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_no_frame();
		test_every_kind();
		test_length_escape();
		test_overflow();
		test_random_frames();

		settle(PAUSE_CYCLES);
		if (replies_due.size() != 0)
			report_mismatch("results never arrived", replies_due.size(), 0);
		$display("Sent %0d commands, checked %0d results under %0d register settings;",
			items_sent, results_checked, settings_used);
		$display("%0d frames closed, %0d parameters dropped for lack of room.",
			frames_closed, drops_seen);
		if (mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

// File: stuffed_parameter_frame_builder_unit.f
design/sfb_pkg.sv
design/sfb_chan_if.sv
design/sfb_ram.sv
design/sfb_emitter.sv
design/stuffed_parameter_frame_builder_unit.sv
dv/tb_top.sv
